@@ src/pfx_pkg.sv @@
// Package for the postfix expression evaluator: constants, codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package pfx_pkg;
  localparam int StackDepth = 64;
  localparam int AddrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  localparam logic [7:0] SymEnd = 8'd35;
  localparam logic [7:0] SymAdd = 8'd43;
  localparam logic [7:0] SymSub = 8'd45;
  localparam logic [7:0] SymMul = 8'd42;
  localparam logic [7:0] SymDiv = 8'd47;
  localparam logic [7:0] SymPow = 8'd94;
  localparam logic [7:0] SymRem = 8'd37;
  localparam logic [7:0] DigitBase = 8'd48;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_POW = 3'd4, OP_REM = 3'd5, OP_END = 3'd6, OP_PUSH = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_sym;   // capture symbol, decode op
    logic rd_top;     // issue read of top entry
    logic rd_next;    // issue read of second entry
    logic cap_r;      // capture read data as right operand
    logic cap_l;      // capture read data as left operand
    logic start_ex;   // start iterative execution
    logic wr_push;    // write pushed operand
    logic wr_res;     // write result below top
    logic set_out;    // build output item
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic lt2;
    logic divz;
    logic ex_done;
  } sts_t;
endpackage
`default_nettype wire

@@ src/postfix_expression_evaluator_unit.sv @@
// Top level of the postfix expression evaluator.
// Depends on pfx_pkg, pfx_ctrl and pfx_datapath.
`default_nettype none
// One symbol is taken per transfer and worked on alone. A successful operand
// push is written to the stack from decode. An overflowing push or an
// operator that finds fewer than two entries goes straight to its output
// step. The end marker reads the top entry and then gives its output. An
// operator reads both operands and then runs in the shared arithmetic unit;
// divide and remainder work out one quotient bit per cycle, and power steps
// once per exponent bit, with a zero or negative exponent giving 1. Operands
// live in a 64-entry RAM with one registered read port, so the two operands
// are fetched on successive cycles. The result register lets the next symbol
// be accepted while a result still waits for its transfer. A symbol that
// gives a result holds in its output step until the previous result has been
// taken. There is no clearing pass: only entries below the stack pointer are
// used.
module postfix_expression_evaluator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  symbol_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      left_operand_o,
  output logic [31:0]      right_operand_o,
  output logic [2:0]       operation_o,
  output logic [31:0]      value_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  import pfx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each symbol; the datapath holds all payload.
  pfx_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts_i(sts), .cmd_o(cmd)
  );

  pfx_datapath u_dp (
    .clk_i, .rst_ni, .symbol_i, .cmd_i(cmd), .sts_o(sts),
    .left_operand_o, .right_operand_o, .operation_o, .value_o, .status_o,
    .last_o
  );
endmodule
`default_nettype wire

@@ src/pfx_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module pfx_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/pfx_alu.sv @@
// Iterative arithmetic unit: add/sub, multiply with registered product,
// 32-step restoring divide and square-and-multiply power.
// Depends on pfx_pkg.
`default_nettype none
module pfx_alu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire pfx_pkg::op_e  op_i,
  input  wire logic [31:0]   l_i,
  input  wire logic [31:0]   r_i,
  output logic               done_o,
  output logic [31:0]        res_o
);
  import pfx_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] a_q, a_d;     // dividend shift / power base
  logic [31:0] b_q, b_d;     // divisor magnitude / exponent
  logic [32:0] rem_q, rem_d; // partial remainder
  logic [31:0] acc_q, acc_d; // quotient / power accumulator
  logic [31:0] res_q, res_d;
  logic        done_q, done_d;
  logic        mul_ph_q, mul_ph_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] p1, p2;
  logic [32:0] trial;
  logic [31:0] lmag, rmag, qs, rs;

  assign lmag = l_i[31] ? (32'd0 - l_i) : l_i;
  assign rmag = r_i[31] ? (32'd0 - r_i) : r_i;
  assign trial = {rem_q[31:0], a_q[31]} - {1'b0, b_q};
  assign p1 = acc_q * a_q;
  assign p2 = a_q * a_q;
  assign qs = (l_i[31] ^ r_i[31]) ? (32'd0 - acc_q) : acc_q;
  assign rs = l_i[31] ? (32'd0 - rem_q[31:0]) : rem_q[31:0];

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; a_d = a_q; b_d = b_q; rem_d = rem_q;
    acc_d = acc_q; res_d = res_q; done_d = 1'b0; mul_ph_d = mul_ph_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 6'd0; mul_ph_d = 1'b0;
      case (op_i)
        OP_DIV, OP_REM: begin
          a_d = lmag; b_d = rmag; rem_d = '0; acc_d = '0;
        end
        OP_POW: begin
          a_d = l_i; b_d = r_i; acc_d = 32'd1;
          if (r_i[31]) b_d = '0;
        end
        default: begin
          a_d = l_i; b_d = r_i;
        end
      endcase
    end else if (busy_q) begin
      case (op_i)
        OP_ADD: begin res_d = l_i + r_i; busy_d = 1'b0; done_d = 1'b1; end
        OP_SUB: begin res_d = l_i - r_i; busy_d = 1'b0; done_d = 1'b1; end
        OP_MUL: begin
          if (!mul_ph_q) begin
            prod_d = a_q * b_q; mul_ph_d = 1'b1;
          end else begin
            res_d = prod_q[31:0]; busy_d = 1'b0; done_d = 1'b1;
          end
        end
        OP_DIV, OP_REM: begin
          if (cnt_q == 6'd32) begin
            res_d = (op_i == OP_DIV) ? qs : rs;
            busy_d = 1'b0; done_d = 1'b1;
          end else begin
            if (!trial[32]) begin
              rem_d = trial; acc_d = {acc_q[30:0], 1'b1};
            end else begin
              rem_d = {rem_q[31:0], a_q[31]}; acc_d = {acc_q[30:0], 1'b0};
            end
            a_d = {a_q[30:0], 1'b0};
            cnt_d = cnt_q + 6'd1;
          end
        end
        OP_POW: begin
          if (b_q == '0) begin
            res_d = acc_q; busy_d = 1'b0; done_d = 1'b1;
          end else begin
            if (b_q[0]) acc_d = p1[31:0];
            a_d = p2[31:0];
            b_d = {1'b0, b_q[31:1]};
          end
        end
        default: begin busy_d = 1'b0; done_d = 1'b1; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; mul_ph_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; mul_ph_q <= mul_ph_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; rem_q <= rem_d; acc_q <= acc_d; res_q <= res_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

@@ src/pfx_datapath.sv @@
// Datapath: symbol decode, stack pointer, stack RAM, operand registers,
// arithmetic unit and output register. Depends on pfx_pkg, pfx_ram, pfx_alu.
`default_nettype none
module pfx_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    symbol_i,
  input  wire pfx_pkg::cmd_t cmd_i,
  output pfx_pkg::sts_t      sts_o,
  output logic [31:0]        left_operand_o,
  output logic [31:0]        right_operand_o,
  output logic [2:0]         operation_o,
  output logic [31:0]        value_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import pfx_pkg::*;

  op_e          op_q, op_dec;
  logic [31:0]  opnd_q;
  logic [CntW-1:0] sp_q, sp_d;
  logic [31:0]  l_q, r_q, rdata;
  logic [AddrW-1:0] raddr, waddr;
  logic         we;
  logic [31:0]  wdata, alu_res;
  logic         alu_done;
  logic         full, empty, lt2, divz;

  always_comb begin
    case (symbol_i)
      SymAdd:  op_dec = OP_ADD;
      SymSub:  op_dec = OP_SUB;
      SymMul:  op_dec = OP_MUL;
      SymDiv:  op_dec = OP_DIV;
      SymPow:  op_dec = OP_POW;
      SymRem:  op_dec = OP_REM;
      SymEnd:  op_dec = OP_END;
      default: op_dec = OP_PUSH;
    endcase
  end

  assign full  = (sp_q == CntW'(StackDepth));
  assign empty = (sp_q == '0);
  assign lt2   = (sp_q < CntW'(2));
  assign divz  = (r_q == '0);

  assign raddr = cmd_i.rd_next ? AddrW'(sp_q - CntW'(2)) : AddrW'(sp_q - CntW'(1));
  assign we    = cmd_i.wr_push | cmd_i.wr_res;
  assign waddr = cmd_i.wr_push ? AddrW'(sp_q) : AddrW'(sp_q - CntW'(2));
  assign wdata = cmd_i.wr_push ? opnd_q : alu_res;

  pfx_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  pfx_alu u_alu (
    .clk_i, .rst_ni, .start_i(cmd_i.start_ex), .op_i(op_q),
    .l_i(l_q), .r_i(r_q), .done_o(alu_done), .res_o(alu_res)
  );

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.wr_push) sp_d = sp_q + CntW'(1);
    else if (cmd_i.wr_res) sp_d = sp_q - CntW'(1);
    else if (cmd_i.set_out && op_q == OP_END) sp_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0; op_q <= OP_PUSH;
    end else begin
      sp_q <= sp_d;
      if (cmd_i.load_sym) op_q <= op_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sym) opnd_q <= 32'(symbol_i - DigitBase) | {{24{symbol_i < DigitBase}}, 8'd0};
    if (cmd_i.cap_r) r_q <= rdata;
    if (cmd_i.cap_l) l_q <= rdata;
    if (cmd_i.set_out) begin
      last_o <= (op_q == OP_END);
      left_operand_o <= '0; right_operand_o <= '0; value_o <= '0;
      if (op_q == OP_PUSH) begin
        operation_o <= OP_ADD; status_o <= ST_OVER; value_o <= opnd_q;
      end else if (op_q == OP_END) begin
        operation_o <= OP_END;
        status_o <= empty ? ST_UNDER : ST_OK;
        if (!empty) value_o <= rdata;
      end else begin
        operation_o <= op_q;
        if (lt2) status_o <= ST_UNDER;
        else begin
          left_operand_o <= l_q; right_operand_o <= r_q;
          if ((op_q == OP_DIV || op_q == OP_REM) && divz) status_o <= ST_DIVZ;
          else begin status_o <= ST_OK; value_o <= alu_res; end
        end
      end
    end
  end

  assign sts_o = '{op: op_q, full: full, empty: empty, lt2: lt2, divz: divz,
                   ex_done: alu_done};
endmodule
`default_nettype wire

@@ src/pfx_ctrl.sv @@
// Controller state machine: sequences decode, stack reads, execution,
// write-back and output. Depends on pfx_pkg.
`default_nettype none
module pfx_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire pfx_pkg::sts_t sts_i,
  output pfx_pkg::cmd_t      cmd_o
);
  import pfx_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001, S_DEC = 8'b0000_0010, S_RDR = 8'b0000_0100,
    S_RDL  = 8'b0000_1000, S_CAPL = 8'b0001_0000, S_EX = 8'b0010_0000,
    S_OUT  = 8'b0100_0000, S_HOLD = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_comb begin
    state_d = state_q; ov_d = ov_q; cmd_o = '0;
    if (ov_q && out_ready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid) begin cmd_o.load_sym = 1'b1; state_d = S_DEC; end
      S_DEC: begin
        if (sts_i.op == OP_PUSH) begin
          if (sts_i.full) state_d = S_OUT;
          else begin cmd_o.wr_push = 1'b1; state_d = S_IDLE; end
        end else if (sts_i.op == OP_END) begin
          cmd_o.rd_top = 1'b1; state_d = S_RDL;
        end else if (sts_i.lt2) state_d = S_OUT;
        else begin cmd_o.rd_top = 1'b1; state_d = S_RDR; end
      end
      S_RDR: begin cmd_o.cap_r = 1'b1; cmd_o.rd_next = 1'b1; state_d = S_CAPL; end
      S_CAPL: begin cmd_o.cap_l = 1'b1; state_d = S_RDL; end
      S_RDL: begin
        if (sts_i.op == OP_END) state_d = S_OUT;
        else begin cmd_o.start_ex = 1'b1; state_d = S_EX; end
      end
      S_EX: if (sts_i.ex_done) state_d = S_OUT;
      S_OUT: if (!ov_q || out_ready) begin
        cmd_o.set_out = 1'b1; ov_d = 1'b1;
        if (sts_i.op != OP_END && sts_i.op != OP_PUSH && !sts_i.lt2 &&
            !((sts_i.op == OP_DIV || sts_i.op == OP_REM) && sts_i.divz))
          cmd_o.wr_res = 1'b1;
        state_d = S_HOLD;
      end
      S_HOLD: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
    end
  end

  assign in_ready  = (state_q == S_IDLE);
  assign out_valid = ov_q;
endmodule
`default_nettype wire

@@ src/pfx_checker.sv @@
// Port-level checker for the postfix evaluator, with its bind statement.
// Depends on pfx_pkg and the top level's ports.
`default_nettype none
module pfx_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  operation_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_o
);
  import pfx_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(operation_o))
    else $error("result dropped while stalled");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_o == (operation_o == OP_END)))
    else $error("last flag disagrees with operation");
  a_over_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o == ST_OVER |-> operation_o == OP_ADD)
    else $error("overflow reported with operator code");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second symbol accepted back to back");
endmodule

bind postfix_expression_evaluator_unit pfx_checker u_pfx_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
  .operation_o, .status_o, .last_o
);
`default_nettype wire

@@ tb/postfix_expression_evaluator_unit_tb.sv @@
// Testbench for the postfix expression evaluator: directed symbol table, then random
// expressions, all checked against an in-bench model of the operand stack.
// Depends on pfx_pkg and postfix_expression_evaluator_unit.
`default_nettype none
module postfix_expression_evaluator_unit_tb;
  import pfx_pkg::*;

  // One predicted evaluator result.
  typedef struct packed {
    logic [31:0] lhs;
    logic [31:0] rhs;
    op_e         op;
    logic [31:0] val;
    status_e     st;
    logic        fin;
  } eval_res_t;

  // One row of the directed table. When has_exp is set, the row also carries the
  // result typed in by hand, and it is checked against the model's result.
  typedef struct {
    logic [7:0] sym;
    bit         has_exp;
    eval_res_t  exp_res;
  } sym_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  symbol_i = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] left_operand_o, right_operand_o, value_o;
  logic [2:0]  operation_o;
  logic [1:0]  status_o;
  logic        last_o;

  postfix_expression_evaluator_unit i_dut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .symbol_i,
    .out_valid, .out_ready, .left_operand_o, .right_operand_o,
    .operation_o, .value_o, .status_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model copy of the operand stack.
  logic [31:0] model_stack [StackDepth];
  int          model_depth = 0;
  eval_res_t   pending_results [$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          long_hold = 1'b0;
  bit          stim_done = 1'b0;

  // Power as the repeated product modulo 2^32; a negative exponent gives 1.
  function automatic logic [31:0] pow_wrap(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc;
    acc = 32'd1;
    if (e[31]) return 32'd1;
    while (e != 0) begin
      if (e[0]) acc = acc * b;
      b = b * b;
      e = e >> 1;
    end
    return acc;
  endfunction

  // Applies one symbol to the model stack; returns 1 and the result if one is due.
  function automatic bit eval_symbol(input logic [7:0] s, output eval_res_t r);
    op_e op;
    logic [31:0] lv, rv, v;
    logic signed [32:0] sl, sr;
    r = '0;
    case (s)
      SymAdd: op = OP_ADD;
      SymSub: op = OP_SUB;
      SymMul: op = OP_MUL;
      SymDiv: op = OP_DIV;
      SymPow: op = OP_POW;
      SymRem: op = OP_REM;
      SymEnd: op = OP_END;
      default: op = OP_PUSH;
    endcase
    if (op == OP_PUSH) begin
      v = {24'd0, s} - {24'd0, DigitBase};
      if (model_depth >= StackDepth) begin
        r = '{32'd0, 32'd0, OP_ADD, v, ST_OVER, 1'b0};
        return 1'b1;
      end
      model_stack[model_depth] = v;
      model_depth++;
      return 1'b0;
    end
    if (op == OP_END) begin
      if (model_depth == 0) r = '{32'd0, 32'd0, OP_END, 32'd0, ST_UNDER, 1'b1};
      else r = '{32'd0, 32'd0, OP_END, model_stack[model_depth-1], ST_OK, 1'b1};
      model_depth = 0;
      return 1'b1;
    end
    if (model_depth < 2) begin
      r = '{32'd0, 32'd0, op, 32'd0, ST_UNDER, 1'b0};
      return 1'b1;
    end
    rv = model_stack[model_depth-1];
    lv = model_stack[model_depth-2];
    sl = {lv[31], lv};
    sr = {rv[31], rv};
    case (op)
      OP_ADD: v = lv + rv;
      OP_SUB: v = lv - rv;
      OP_MUL: v = lv * rv;
      OP_POW: v = pow_wrap(lv, rv);
      default: begin
        if (rv == 0) begin
          r = '{lv, rv, op, 32'd0, ST_DIVZ, 1'b0};
          return 1'b1;
        end
        // 33-bit signed math keeps the most negative over -1 case exact before wrapping.
        if (op == OP_DIV) v = 32'(sl / sr);
        else v = 32'(sl % sr);
      end
    endcase
    model_depth--;
    model_stack[model_depth-1] = v;
    r = '{lv, rv, op, v, ST_OK, 1'b0};
    return 1'b1;
  endfunction

  // Sends one symbol after a random gap and books its expected result. Valid stays
  // high after the transfer until the next call decides on a gap.
  task automatic send_symbol(input logic [7:0] s, input bit has_exp = 1'b0,
                             input eval_res_t exp_res = '0);
    eval_res_t r;
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    symbol_i <= s;
    do @(posedge clk_i); while (!in_ready);
    if (eval_symbol(s, r)) begin
      if (has_exp && r !== exp_res) begin
        $display("%0t: table row for symbol %0d expected %h, model gives %h",
                 $time, s, exp_res, r);
        errors++;
      end
      pending_results.push_back(r);
    end
  endtask

  // Random symbol: mostly digits and operators, some of any byte value.
  function automatic logic [7:0] rand_symbol();
    logic [7:0] ops [6];
    ops = '{SymAdd, SymSub, SymMul, SymDiv, SymPow, SymRem};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DigitBase + 8'($urandom_range(0, 9));
      4, 5, 6:    return ops[$urandom_range(0, 5)];
      7:          return SymEnd;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stops offering symbols and waits until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Each accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    eval_res_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h %h %0d %h %0d %0d",
                 $time, left_operand_o, right_operand_o, operation_o, value_o,
                 status_o, last_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (left_operand_o !== want.lhs) begin
          $display("%0t: left_operand expected %h actual %h", $time, want.lhs,
                   left_operand_o);
          errors++;
        end
        if (right_operand_o !== want.rhs) begin
          $display("%0t: right_operand expected %h actual %h", $time, want.rhs,
                   right_operand_o);
          errors++;
        end
        if (operation_o !== want.op) begin
          $display("%0t: operation expected %0d actual %0d", $time, want.op,
                   operation_o);
          errors++;
        end
        if (value_o !== want.val) begin
          $display("%0t: value expected %h actual %h", $time, want.val, value_o);
          errors++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          errors++;
        end
        if (last_o !== want.fin) begin
          $display("%0t: last expected %0d actual %0d", $time, want.fin, last_o);
          errors++;
        end
      end
    end
  end

  // Receiver: ready drawn per transfer, with a long hold-off when requested.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w != 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid && !long_hold);
    end
  end

  // Watchdog sized for ~1000 items plus gaps and stalls.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  sym_row_t dir_rows [$];

  initial begin
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Underflow cases on an empty stack, then every operator on live data, division
    // by zero, and a negative exponent.
    dir_rows = '{
      '{SymEnd, 1'b1, '{32'd0, 32'd0, OP_END, 32'd0, ST_UNDER, 1'b1}},
      '{SymAdd, 1'b1, '{32'd0, 32'd0, OP_ADD, 32'd0, ST_UNDER, 1'b0}},
      '{8'd55, 1'b0, '0}, '{8'd51, 1'b0, '0},
      '{SymSub, 1'b0, '0}, '{8'd0, 1'b0, '0}, '{SymMul, 1'b0, '0},
      '{8'd48, 1'b0, '0},
      '{SymDiv, 1'b1, '{32'hFFFF_FF40, 32'd0, OP_DIV, 32'd0, ST_DIVZ, 1'b0}},
      '{SymRem, 1'b1, '{32'hFFFF_FF40, 32'd0, OP_REM, 32'd0, ST_DIVZ, 1'b0}},
      '{8'd255, 1'b0, '0}, '{SymRem, 1'b0, '0}, '{8'd47 + 8'd2, 1'b0, '0},
      '{SymPow, 1'b0, '0}, '{8'd0, 1'b0, '0}, '{SymPow, 1'b0, '0},
      '{8'd57, 1'b0, '0}, '{SymAdd, 1'b0, '0}, '{SymDiv, 1'b0, '0},
      '{SymEnd, 1'b0, '0}
    };
    foreach (dir_rows[i]) send_symbol(dir_rows[i].sym, dir_rows[i].has_exp,
                                      dir_rows[i].exp_res);

    // Most negative divided by -1, then its remainder by -1: 2^31 comes from power,
    // and -1 from 0 - 1.
    send_symbol(8'd50); send_symbol(8'd48 + 8'd31); send_symbol(SymPow);
    send_symbol(8'd48); send_symbol(8'd49); send_symbol(SymSub); send_symbol(SymDiv);
    send_symbol(8'd50); send_symbol(8'd48 + 8'd31); send_symbol(SymPow);
    send_symbol(8'd48); send_symbol(8'd49); send_symbol(SymSub); send_symbol(SymRem);
    send_symbol(SymEnd);

    // Fill the stack, then push past the top with the receiver stalled so that the
    // overflow results pile up and the input stalls.
    for (int i = 0; i < StackDepth; i++) send_symbol(8'($urandom_range(0, 255)) | 8'h80);
    long_hold = 1'b1;
    for (int i = 0; i < 3; i++) send_symbol(8'($urandom_range(0, 255)) | 8'h80);
    send_symbol(SymEnd);
    wait_drained();

    // Random well-formed expressions with random content, mixed with noise.
    n = 0;
    while (n < 750) begin
      if ($urandom_range(0, 4) != 0) begin
        send_symbol(DigitBase + 8'($urandom_range(0, 9)));
        n++;
        repeat ($urandom_range(0, 6)) begin
          send_symbol(($urandom_range(0, 1) == 0) ? DigitBase + 8'($urandom_range(0, 9))
                                                  : 8'($urandom_range(0, 255)));
          send_symbol(rand_symbol());
          n += 2;
        end
        send_symbol(SymEnd);
        n++;
      end else begin
        send_symbol(rand_symbol());
        n++;
      end
      if (n > 400 && n < 410) wait_drained();
    end
    send_symbol(SymEnd);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
